@@ src/pha_pkg.sv @@
// Shared constants, widths and the arctangent table for the path heading assigner.
// No dependencies; every other file uses it by scoped names.
package pha_pkg;

	localparam int POS_W   = 32;
	localparam int YAW_W   = 16;
	localparam int LEN_W   = 40;
	localparam int DIST_W  = 34;
	localparam int MIND_W  = 21;
	localparam int OMNI_W  = 5;
	localparam int NUM_W   = 40;

	localparam int CORDIC_STEPS = 30;

	// register select, taken from paddr[2]
	localparam logic REG_MIN_DIST = 1'b0;
	localparam logic REG_OMNI     = 1'b1;

	localparam logic [MIND_W-1:0] MIN_DIST_RST = 21'd3277;
	localparam logic [OMNI_W-1:0] OMNI_RST     = 5'd20;

	// atan(2^-k), 2^32 per turn
	function automatic logic [31:0] atan_lut(input logic [4:0] k);
		logic [31:0] v;
		unique case (k)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ src/pha_in_if.sv @@
// Input point channel: valid/ready plus one path point per beat.
// Depends on pha_pkg for field widths.
interface pha_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [pha_pkg::POS_W-1:0] pos_x;
	logic signed [pha_pkg::POS_W-1:0] pos_y;
	logic        [pha_pkg::YAW_W-1:0] heading;
	logic                             last_point;

	modport source (output valid, pos_x, pos_y, heading, last_point, input ready);
	modport sink   (input valid, pos_x, pos_y, heading, last_point, output ready);
endinterface

@@ src/pha_out_if.sv @@
// Output pose channel: valid/ready plus one kept point with its yaw per beat.
// Depends on pha_pkg for field widths.
interface pha_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [pha_pkg::POS_W-1:0] out_x;
	logic signed [pha_pkg::POS_W-1:0] out_y;
	logic        [pha_pkg::YAW_W-1:0] out_yaw;
	logic                             end_of_path;
	logic                             overflowed;

	modport source (output valid, out_x, out_y, out_yaw, end_of_path, overflowed, input ready);
	modport sink   (input valid, out_x, out_y, out_yaw, end_of_path, overflowed, output ready);
endinterface

@@ src/path_heading_assigner_top.sv @@
// Path heading assigner top level: point store, sequencer, output register, APB regs.
// Depends on pha_pkg, pha_in_if, pha_out_if, pha_sqrt, pha_cordic, pha_blend.
//
// Channel  Dir  Beat contents
// in_ch    in   pos_x, pos_y, heading, last_point
// out_ch   out  out_x, out_y, out_yaw, end_of_path, overflowed
// APB      in   min_distance at 0x0, omni_poses at 0x4
//
// Inner point: one 32-step square root for the segment length.
// Last point: a long path first computes its two end bearings, then each emitted
// point takes a root + divide, a divide, or a normalize + 30-step CORDIC;
// the end points need only store reads.
// Reset clears path state and config to 3277 / 20; the store needs no clearing.
// in_ch.ready is high only in S_IDLE; output stalls hold the sequencer.
module path_heading_assigner_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	pha_in_if.sink      in_ch,
	pha_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int CMPW = ((CW > 5) ? CW : 5) + 2;

	typedef enum logic [4:0] {
		S_IDLE, S_LGO, S_LEN,
		S_PRE_A, S_PRE_B, S_PRE_C, S_PRE_GO, S_PRE_WAIT,
		S_W_RD0, S_W_CUR, S_W_RDN, S_W_NXT, S_W_GO, S_W_SQ, S_W_BGO, S_W_WAIT,
		S_EMIT
	} state_t;

	// config registers
	logic [pha_pkg::MIND_W-1:0] min_q;
	logic [pha_pkg::OMNI_W-1:0] omni_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= pha_pkg::MIN_DIST_RST;
			omni_q <= pha_pkg::OMNI_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				pha_pkg::REG_MIN_DIST: min_q  <= pwdata[pha_pkg::MIND_W-1:0];
				pha_pkg::REG_OMNI:     omni_q <= pwdata[pha_pkg::OMNI_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pha_pkg::REG_MIN_DIST: prdata = 32'(min_q);
			pha_pkg::REG_OMNI:     prdata = 32'(omni_q);
			default:               prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	// point store, {x, y}
	logic [63:0]   mem [MAX_POINTS];
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {in_ch.pos_x, in_ch.pos_y};
		end
		rdata_q <= mem[raddr];
	end

	state_t        state_q;
	logic [CW-1:0] kept_q, n_q, i_q;
	logic [pha_pkg::LEN_W-1:0] len_q, trav_q;
	logic [15:0]   start_q, goal_q, target_q, from_q, yaw_q;
	logic          ovf_q, long_q, pre_sel_q;
	logic signed [31:0] cur_x, cur_y, nxt_x, nxt_y, prv_x, prv_y;
	logic          ovalid_q, oend_q, oovf_q;
	logic signed [31:0] ox_q, oy_q;
	logic [15:0]   oyaw_q;

	logic          in_acc, can_load, out_load;
	logic [4:0]    m_val;
	logic [CMPW-1:0] kept_w, n_w, m_w, i_w, tail_w, nl_w;
	logic          long_now, i_last;

	// unit hookups
	logic          sq_start, sq_done;
	logic signed [32:0] sq_dx, sq_dy, co_dx, co_dy;
	logic [pha_pkg::DIST_W-1:0] sq_len;
	logic          co_start, co_done;
	logic [15:0]   co_ang;
	logic          bl_start, bl_done;
	logic [15:0]   bl_from, bl_to, bl_yaw;
	logic [pha_pkg::NUM_W-1:0] bl_num, bl_den;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign can_load = !ovalid_q || out_ch.ready;
	assign out_load = (state_q == S_EMIT) && can_load;
	assign m_val    = (omni_q == '0) ? 5'd1 : omni_q;
	assign kept_w   = CMPW'(kept_q);
	assign n_w      = CMPW'(n_q);
	assign m_w      = CMPW'(m_val);
	assign i_w      = CMPW'(i_q);
	assign nl_w     = kept_w + CMPW'(1);
	assign long_now = nl_w >= ((m_w << 1) + CMPW'(2));
	assign tail_w   = n_w - m_w - CMPW'(1);
	assign i_last   = i_w == (n_w - CMPW'(1));

	assign we    = in_acc;
	assign waddr = kept_q[AW-1:0];

	always_comb begin
		unique case (state_q)
			S_PRE_A: raddr = pre_sel_q ? AW'(tail_w) : AW'(m_w);
			S_PRE_B: raddr = pre_sel_q ? AW'(n_w - m_w) : AW'(m_w + CMPW'(1));
			S_W_RD0: raddr = '0;
			S_W_CUR, S_W_RDN: raddr = AW'(i_w + CMPW'(1));
			default: raddr = '0;
		endcase
	end

	assign sq_dx    = 33'(cur_x) - 33'(prv_x);
	assign sq_dy    = 33'(cur_y) - 33'(prv_y);
	assign co_dx    = 33'(nxt_x) - 33'(cur_x);
	assign co_dy    = 33'(nxt_y) - 33'(cur_y);
	assign sq_start = (state_q == S_LGO) || (state_q == S_W_GO && !i_last && i_q != '0 && !long_q);
	assign co_start = (state_q == S_PRE_GO) ||
		(state_q == S_W_GO && !i_last && i_q != '0 && long_q && i_w > m_w && i_w < tail_w);
	assign bl_start = state_q == S_W_BGO;

	always_comb begin
		if (!long_q) begin
			bl_from = start_q;
			bl_to   = goal_q;
			bl_num  = trav_q;
			bl_den  = len_q;
		end else if (i_w <= m_w) begin
			bl_from = start_q;
			bl_to   = target_q;
			bl_num  = pha_pkg::NUM_W'(i_w);
			bl_den  = pha_pkg::NUM_W'(m_w);
		end else begin
			bl_from = from_q;
			bl_to   = goal_q;
			bl_num  = pha_pkg::NUM_W'(i_w - tail_w);
			bl_den  = pha_pkg::NUM_W'(m_w);
		end
	end

	pha_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .dx(sq_dx), .dy(sq_dy),
		.done(sq_done), .len(sq_len)
	);

	pha_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(co_start), .dx(co_dx), .dy(co_dy),
		.done(co_done), .angle(co_ang)
	);

	pha_blend u_blend (
		.clk(clk), .arst_n(arst_n), .start(bl_start), .from(bl_from), .to(bl_to),
		.num(bl_num), .den(bl_den), .done(bl_done), .yaw(bl_yaw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kept_q    <= '0;
			n_q       <= '0;
			i_q       <= '0;
			len_q     <= '0;
			trav_q    <= '0;
			start_q   <= '0;
			ovf_q     <= 1'b0;
			long_q    <= 1'b0;
			pre_sel_q <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (out_ch.ready && !out_load) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cur_x <= in_ch.pos_x;
						cur_y <= in_ch.pos_y;
						if (kept_q == '0) begin
							start_q <= in_ch.heading;
							len_q   <= '0;
							ovf_q   <= 1'b0;
							prv_x   <= in_ch.pos_x;
							prv_y   <= in_ch.pos_y;
							if (in_ch.last_point) begin
								// single point path
								yaw_q   <= in_ch.heading;
								n_q     <= CW'(1);
								i_q     <= '0;
								state_q <= S_EMIT;
							end else begin
								kept_q <= CW'(1);
							end
						end else if (in_ch.last_point) begin
							goal_q    <= in_ch.heading;
							n_q       <= CW'(nl_w);
							i_q       <= '0;
							trav_q    <= '0;
							long_q    <= long_now;
							pre_sel_q <= 1'b0;
							state_q   <= long_now ? S_PRE_A : S_W_RD0;
						end else begin
							state_q <= S_LGO;
						end
					end
				end
				S_LGO: state_q <= S_LEN;
				S_LEN: begin
					if (sq_done) begin
						if (sq_len >= pha_pkg::DIST_W'(min_q)) begin
							if (kept_q >= CW'(MAX_POINTS - 1)) begin
								ovf_q <= 1'b1;
							end else begin
								kept_q <= kept_q + CW'(1);
								len_q  <= len_q + pha_pkg::LEN_W'(sq_len);
								prv_x  <= cur_x;
								prv_y  <= cur_y;
							end
						end
						state_q <= S_IDLE;
					end
				end
				S_PRE_A: state_q <= S_PRE_B;
				S_PRE_B: begin
					cur_x   <= rdata_q[63:32];
					cur_y   <= rdata_q[31:0];
					state_q <= S_PRE_C;
				end
				S_PRE_C: begin
					nxt_x   <= rdata_q[63:32];
					nxt_y   <= rdata_q[31:0];
					state_q <= S_PRE_GO;
				end
				S_PRE_GO: state_q <= S_PRE_WAIT;
				S_PRE_WAIT: begin
					if (co_done) begin
						if (!pre_sel_q) begin
							target_q  <= co_ang;
							pre_sel_q <= 1'b1;
							state_q   <= S_PRE_A;
						end else begin
							from_q  <= co_ang;
							state_q <= S_W_RD0;
						end
					end
				end
				S_W_RD0: state_q <= S_W_CUR;
				S_W_CUR: begin
					cur_x   <= rdata_q[63:32];
					cur_y   <= rdata_q[31:0];
					state_q <= S_W_NXT;
				end
				S_W_RDN: state_q <= S_W_NXT;
				S_W_NXT: begin
					nxt_x   <= rdata_q[63:32];
					nxt_y   <= rdata_q[31:0];
					state_q <= S_W_GO;
				end
				S_W_GO: begin
					if (i_q == '0) begin
						yaw_q   <= start_q;
						state_q <= S_EMIT;
					end else if (i_last) begin
						yaw_q   <= goal_q;
						state_q <= S_EMIT;
					end else if (!long_q) begin
						state_q <= S_W_SQ;
					end else if (i_w <= m_w || i_w >= tail_w) begin
						state_q <= S_W_BGO;
					end else begin
						state_q <= S_W_WAIT;
					end
				end
				S_W_SQ: begin
					if (sq_done) begin
						trav_q  <= trav_q + pha_pkg::LEN_W'(sq_len);
						state_q <= S_W_BGO;
					end
				end
				S_W_BGO: state_q <= S_W_WAIT;
				S_W_WAIT: begin
					if (bl_done) begin
						yaw_q   <= bl_yaw;
						state_q <= S_EMIT;
					end else if (co_done) begin
						yaw_q   <= co_ang;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_load) begin
						ovalid_q <= 1'b1;
						ox_q     <= cur_x;
						oy_q     <= cur_y;
						oyaw_q   <= yaw_q;
						oend_q   <= i_last;
						oovf_q   <= ovf_q;
						if (i_last) begin
							kept_q  <= '0;
							len_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							prv_x   <= cur_x;
							prv_y   <= cur_y;
							cur_x   <= nxt_x;
							cur_y   <= nxt_y;
							i_q     <= i_q + CW'(1);
							state_q <= S_W_RDN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready        = state_q == S_IDLE;
	assign out_ch.valid       = ovalid_q;
	assign out_ch.out_x       = ox_q;
	assign out_ch.out_y       = oy_q;
	assign out_ch.out_yaw     = oyaw_q;
	assign out_ch.end_of_path = oend_q;
	assign out_ch.overflowed  = oovf_q;
endmodule

@@ src/pha_sqrt.sv @@
// Segment length unit: floor(sqrt(dx^2+dy^2)) below 2^31 magnitude, one result bit per cycle.
// Depends on pha_pkg.
module pha_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [32:0]          dx,
	input  logic signed [32:0]          dy,
	output logic                        done,
	output logic [pha_pkg::DIST_W-1:0]  len
);
	typedef enum logic [1:0] {S_IDLE, S_SQ, S_ADD, S_RUN} state_t;

	state_t      state_q;
	logic [32:0] ax, ay;
	logic        half;
	logic [30:0] ax_q, ay_q;
	logic        half_q;
	logic [61:0] sqx_q, sqy_q;
	logic [62:0] v_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic [63:0] trial;
	logic        ge;
	logic [62:0] r_nxt;
	logic        done_q;
	logic [pha_pkg::DIST_W-1:0] len_q;

	assign ax    = dx[32] ? 33'(-dx) : 33'(dx);
	assign ay    = dy[32] ? 33'(-dy) : 33'(dy);
	// magnitudes at or above 2^31 are halved and the root doubled
	assign half  = (|ax[32:31]) | (|ay[32:31]);
	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign ge    = {1'b0, v_q} >= trial;
	assign r_nxt = ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= (state_q == S_RUN) && (cnt_q == 5'd31);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ax_q    <= half ? ax[31:1] : ax[30:0];
						ay_q    <= half ? ay[31:1] : ay[30:0];
						half_q  <= half;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sqx_q   <= ax_q * ax_q;
					sqy_q   <= ay_q * ay_q;
					state_q <= S_ADD;
				end
				S_ADD: begin
					v_q     <= {1'b0, sqx_q} + {1'b0, sqy_q};
					r_q     <= '0;
					bit_q   <= 63'd1 << 62;
					cnt_q   <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (ge) begin
						v_q <= v_q - trial[62:0];
					end
					r_q   <= r_nxt;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						len_q   <= half_q ? {1'b0, r_nxt[31:0], 1'b0} : {2'b00, r_nxt[31:0]};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign len  = len_q;
endmodule

@@ src/pha_cordic.sv @@
// Bearing unit: normalizes the vector one shift a cycle, then runs a
// 30-step vectoring CORDIC and rounds to a 16-bit binary angle. Depends on pha_pkg.
module pha_cordic (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [32:0]          dx,
	input  logic signed [32:0]          dy,
	output logic                        done,
	output logic [pha_pkg::YAW_W-1:0]   angle
);
	typedef enum logic [1:0] {S_IDLE, S_NORM, S_ITER, S_FIN} state_t;

	state_t             state_q;
	logic [32:0]        ax, ay;
	logic [32:0]        ax_q, ay_q;
	logic               sx_q, sy_q;
	logic signed [35:0] x_q, y_q, tx, ty;
	logic signed [32:0] z_q, at;
	logic [4:0]         k_q;
	logic [30:0]        q;
	logic [31:0]        r, rr;
	logic               done_q;
	logic [pha_pkg::YAW_W-1:0] ang_q;

	assign ax = dx[32] ? 33'(-dx) : 33'(dx);
	assign ay = dy[32] ? 33'(-dy) : 33'(dy);
	assign tx = x_q >>> k_q;
	assign ty = y_q >>> k_q;
	assign at = signed'({1'b0, pha_pkg::atan_lut(k_q)});

	always_comb begin
		if (z_q < 0) begin
			q = '0;
		end else if (z_q > 33'sh040000000) begin
			q = 31'h40000000;
		end else begin
			q = z_q[30:0];
		end
		priority if (!sx_q && !sy_q) begin
			r = {1'b0, q};
		end else if (sx_q && !sy_q) begin
			r = 32'h80000000 - {1'b0, q};
		end else if (sx_q) begin
			r = 32'h80000000 + {1'b0, q};
		end else begin
			r = 32'h0 - {1'b0, q};
		end
		rr = r + 32'h00008000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			// zero vector finishes at once, others after the rounding step
			done_q <= (state_q == S_FIN) ||
				(state_q == S_IDLE && start && ax == '0 && ay == '0);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						sx_q <= dx[32];
						sy_q <= dy[32];
						ax_q <= ax;
						ay_q <= ay;
						if (ax == '0 && ay == '0) begin
							// zero vector has bearing zero
							ang_q <= '0;
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (ax_q[32:31] == 2'b00 && ay_q[32:31] == 2'b00) begin
						ax_q <= ax_q << 1;
						ay_q <= ay_q << 1;
					end else begin
						x_q     <= signed'({3'b000, ax_q});
						y_q     <= signed'({3'b000, ay_q});
						z_q     <= '0;
						k_q     <= '0;
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					if (!y_q[35]) begin
						x_q <= x_q + ty;
						y_q <= y_q - tx;
						z_q <= z_q + at;
					end else begin
						x_q <= x_q - ty;
						y_q <= y_q + tx;
						z_q <= z_q - at;
					end
					k_q <= k_q + 5'd1;
					if (k_q == 5'(pha_pkg::CORDIC_STEPS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					ang_q   <= rr[31:16];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign angle = ang_q;
endmodule

@@ src/pha_blend.sv @@
// Blend unit: turns from one yaw toward another the shorter way by num/den,
// rounded half up; restoring divide, one quotient bit a cycle. Depends on pha_pkg.
module pha_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pha_pkg::YAW_W-1:0]   from,
	input  logic [pha_pkg::YAW_W-1:0]   to,
	input  logic [pha_pkg::NUM_W-1:0]   num,
	input  logic [pha_pkg::NUM_W-1:0]   den,
	output logic                        done,
	output logic [pha_pkg::YAW_W-1:0]   yaw
);
	localparam int PW = pha_pkg::YAW_W + pha_pkg::NUM_W;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_DIV, S_FIN} state_t;

	state_t      state_q;
	logic [15:0] way1, way2, way;
	logic        pos;
	logic [15:0] from_q, way_q, step_q;
	logic        pos_q;
	logic [pha_pkg::NUM_W-1:0] num_q, den_q;
	logic [PW-1:0]  prod_q;
	logic [PW:0]    rem_q;
	logic [PW-1:0]  dsh_q;
	logic [3:0]     cnt_q;
	logic           ge;
	logic           done_q;
	logic [15:0]    yaw_q;

	assign way1 = to - from;
	assign way2 = from - to;
	// equal ways turn the negative way
	assign pos  = way1 < way2;
	assign way  = pos ? way1 : way2;
	assign ge   = rem_q >= (PW+1)'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= state_q == S_FIN;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						from_q <= from;
						pos_q  <= pos;
						way_q  <= way;
						num_q  <= num;
						den_q  <= den;
						if (den == '0 || num >= den) begin
							step_q  <= way;
							state_q <= S_FIN;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					prod_q  <= way_q * num_q;
					state_q <= S_ADD;
				end
				S_ADD: begin
					rem_q   <= (PW+1)'(prod_q) + (PW+1)'(den_q >> 1);
					dsh_q   <= PW'({den_q, 15'd0});
					step_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (ge) begin
						rem_q <= rem_q - (PW+1)'(dsh_q);
					end
					step_q <= {step_q[14:0], ge};
					dsh_q  <= dsh_q >> 1;
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					yaw_q   <= pos_q ? (from_q + step_q) : (from_q - step_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign yaw  = yaw_q;
endmodule

@@ src/pha_checker.sv @@
// Port-level checks for the path heading assigner, bound to the top level.
// Depends on pha_pkg and path_heading_assigner_top.
module pha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_x,
	input logic [31:0] out_y,
	input logic [pha_pkg::YAW_W-1:0] out_yaw,
	input logic        end_of_path,
	input logic        overflowed
);
	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_yaw) && $stable(end_of_path) && $stable(overflowed))
		else $error("output beat changed while stalled");

	// taking the last point starts emission, so input closes
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input open right after last point");

	// no new point while a path is still being emitted
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_path |-> !in_ready)
		else $error("input open during emission");

	// overflow flag is constant over one path
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !end_of_path |=> !out_valid
			|| (overflowed == $past(overflowed)))
		else $error("overflow flag changed within a path");
endmodule

bind path_heading_assigner_top pha_checker u_pha_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_point),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_x(out_ch.out_x), .out_y(out_ch.out_y), .out_yaw(out_ch.out_yaw),
	.end_of_path(out_ch.end_of_path), .overflowed(out_ch.overflowed)
);
